@@ rtl/ilt_pkg.sv @@
// ----------------------------------------------------------------------------
// ilt_pkg
// Types and character codes for the integer literal token validator.
// ----------------------------------------------------------------------------
package ilt_pkg;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_ZERO      = 4'd1,
    ST_DEC       = 4'd2,
    ST_OCT       = 4'd3,
    ST_BIN_EMPTY = 4'd4,
    ST_BIN       = 4'd5,
    ST_HEX_EMPTY = 4'd6,
    ST_HEX       = 4'd7,
    ST_SKIP      = 4'd8
  } lex_state_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

endpackage

@@ rtl/integer_literal_token_validator_core.sv @@
// ----------------------------------------------------------------------------
// integer_literal_token_validator_core
// Byte-stream lexer that checks space/newline separated tokens for valid
// decimal, octal, binary or hex integer literals.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload
//  -------   -----------------   ----------------------
//  input     in_valid/in_ready   char_byte[7:0]
//  output    out_valid/out_ready token_valid, line_end
//
// One byte per clock sustained while the result is not stalled. A byte is held
// in the input register, then one state transition updates the lexer state and,
// at a separator that ends a token, loads the result register.
// Reset returns the lexer to start of token and empties both registers.
// A stalled result holds the lexer stage; the input register still takes one
// more byte if it is empty, then in_ready drops.

module integer_literal_token_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       token_valid,
  output logic       line_end
);

  logic                stage_valid;
  logic [7:0]          stage_char;
  ilt_pkg::lex_state_t parse_state;
  ilt_pkg::lex_state_t parse_state_next;

  logic advance;
  logic is_sep;
  logic is_nl;
  logic is_dec;
  logic is_oct;
  logic is_bin;
  logic is_hex;
  logic emit;
  logic ok;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_char <= char_byte;
    end
  end

  // character classes
  always_comb begin
    is_nl  = (stage_char == ilt_pkg::CH_NEWLINE);
    is_sep = is_nl || (stage_char == ilt_pkg::CH_SPACE);
    is_dec = stage_char inside {[ilt_pkg::CH_ZERO : ilt_pkg::CH_NINE]};
    is_oct = stage_char inside {[ilt_pkg::CH_ZERO : ilt_pkg::CH_SEVEN]};
    is_bin = (stage_char == ilt_pkg::CH_ZERO) || (stage_char == ilt_pkg::CH_ONE);
    is_hex = is_dec ||
             (stage_char inside {[ilt_pkg::CH_UPPER_A : ilt_pkg::CH_UPPER_F]});
  end

  // next state
  always_comb begin
    parse_state_next = parse_state;
    if (parse_state == ilt_pkg::ST_START) begin
      // separators at token start are swallowed and poison the next token
      if (stage_char == ilt_pkg::CH_ZERO) begin
        parse_state_next = ilt_pkg::ST_ZERO;
      end else if (is_dec) begin
        parse_state_next = ilt_pkg::ST_DEC;
      end else begin
        parse_state_next = ilt_pkg::ST_SKIP;
      end
    end else if (is_sep) begin
      parse_state_next = ilt_pkg::ST_START;
    end else begin
      case (parse_state)
        ilt_pkg::ST_ZERO: begin
          if (is_oct) begin
            parse_state_next = ilt_pkg::ST_OCT;
          end else if (stage_char == ilt_pkg::CH_LOWER_B) begin
            parse_state_next = ilt_pkg::ST_BIN_EMPTY;
          end else if (stage_char == ilt_pkg::CH_LOWER_X) begin
            parse_state_next = ilt_pkg::ST_HEX_EMPTY;
          end else begin
            parse_state_next = ilt_pkg::ST_SKIP;
          end
        end
        ilt_pkg::ST_DEC: begin
          parse_state_next = is_dec ? ilt_pkg::ST_DEC : ilt_pkg::ST_SKIP;
        end
        ilt_pkg::ST_OCT: begin
          parse_state_next = is_oct ? ilt_pkg::ST_OCT : ilt_pkg::ST_SKIP;
        end
        ilt_pkg::ST_BIN_EMPTY, ilt_pkg::ST_BIN: begin
          parse_state_next = is_bin ? ilt_pkg::ST_BIN : ilt_pkg::ST_SKIP;
        end
        ilt_pkg::ST_HEX_EMPTY, ilt_pkg::ST_HEX: begin
          parse_state_next = is_hex ? ilt_pkg::ST_HEX : ilt_pkg::ST_SKIP;
        end
        default: begin
          parse_state_next = ilt_pkg::ST_SKIP;
        end
      endcase
    end
  end

  // result outputs
  always_comb begin
    emit = (parse_state != ilt_pkg::ST_START) && is_sep;
    case (parse_state)
      ilt_pkg::ST_ZERO, ilt_pkg::ST_DEC, ilt_pkg::ST_OCT,
      ilt_pkg::ST_BIN, ilt_pkg::ST_HEX: ok = 1'b1;
      default:                          ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ilt_pkg::ST_START;
    end else if (advance) begin
      parse_state <= parse_state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      token_valid <= ok;
      line_end    <= is_nl;
    end
  end

endmodule
